// ----- sv/dqtm_pkg.sv -----
// Package with shared types and constants of the delta queue timer manager.
package dqtm_pkg;
	localparam int Depth = 16;
	localparam int SlotW = $clog2(Depth);
	localparam int LenW = $clog2(Depth + 1);
	localparam int TimeW = 48;
	localparam int MaxOut = 16;
	localparam int OutW = $clog2(MaxOut + 1);

	localparam logic [1:0] KIND_SET = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	localparam logic [2:0] ST_SET_OK = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_CANCELLED = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_EXPIRED = 3'd4;
	localparam logic [2:0] ST_NONE = 3'd5;

	typedef struct packed {
		logic [1:0] kind;
		logic [30:0] timeout_ms;
		logic [15:0] user_tag;
		logic [3:0] cancel_slot;
		logic [47:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] slot;
		logic [15:0] tag;
		logic last;
	} rsp_t;
endpackage

// ----- sv/dqtm_if.sv -----
// Valid/ready channel interface carrying one payload.
interface dqtm_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/dqtm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module dqtm_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- sv/delta_queue_timer_manager.sv -----
// Top level of the delta queue timer manager: sequencer over the queue memories.
//
// Usage: requests arrive on the req channel (set, cancel, tick) and results
// leave on the rsp channel, one request at a time. A set or cancel gives one
// result; a tick gives one result per expired timer (at most 16), the final
// one marked with last, or one none-expired result.
// The queue lives in a delta memory (48-bit) and a slot memory (4-bit), both
// with registered read data, plus a per-slot tag memory. An operation that
// walks the ordered queue takes one entry at a time: a read, then a check or
// a write back. A set searches for its position and then shifts the later
// entries up to insert (when it appends, nothing is shifted); a cancel finds
// its slot and then moves the later entries down; a full queue or an unknown
// slot is answered without a walk; a tick unlinks each expired head and
// checks the new head after each one.
// After reset the queue is empty, all slots are free and the stored time is
// zero; memories need no clearing since only entries below the length are read.
// When the receiver stalls, the block holds its result in an output register
// and stops advancing until it is taken.
module delta_queue_timer_manager (
	input logic clk,
	input logic arst_n,
	dqtm_if.sink req,
	dqtm_if.source rsp
);
	localparam int SW = dqtm_pkg::SlotW;
	localparam int LW = dqtm_pkg::LenW;
	localparam int TW = dqtm_pkg::TimeW;
	localparam int OW = dqtm_pkg::OutW;

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_SHIFT_RD, S_SHIFT_WR, S_INS,
		S_FIND_RD, S_FIND_CHK, S_UNL_RD, S_UNL_WR, S_TICK_RD, S_TICK_CHK,
		S_OUT
	} state_t;

	state_t state_q;
	dqtm_pkg::req_t req_q;
	logic [dqtm_pkg::Depth-1:0] busy_q;
	logic [LW-1:0] len_q;
	logic [TW-1:0] time_q;
	logic [TW-1:0] trig_q;
	logic [TW-1:0] sum_q;
	logic [TW-1:0] acc_q;
	logic [LW-1:0] idx_q;
	logic [LW-1:0] pos_q;
	logic [SW-1:0] free_q;
	logic [OW-1:0] nout_q;
	logic tick_q;
	logic hold_q;
	logic rsp_valid_q;
	dqtm_pkg::rsp_t rsp_q;

	// Memory ports.
	logic d_we, s_we, t_we;
	logic [SW-1:0] d_waddr, d_raddr, s_waddr, s_raddr, t_waddr, t_raddr;
	logic [TW-1:0] d_wdata, d_rdata;
	logic [SW-1:0] s_wdata, s_rdata;
	logic [15:0] t_rdata;

	dqtm_ram #(.Width(TW), .Depth(dqtm_pkg::Depth)) u_delta (
		.clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata)
	);
	dqtm_ram #(.Width(SW), .Depth(dqtm_pkg::Depth)) u_qslot (
		.clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
	);
	dqtm_ram #(.Width(16), .Depth(dqtm_pkg::Depth)) u_tag (
		.clk, .we(t_we), .waddr(t_waddr), .wdata(req_q.user_tag), .raddr(t_raddr),
		.rdata(t_rdata)
	);

	// Lowest free slot.
	logic [SW-1:0] free_idx;
	logic free_any;
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = dqtm_pkg::Depth - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_idx = SW'(i);
				free_any = 1'b1;
			end
		end
	end

	// Saturating trigger time.
	logic [TW:0] trig_sum;
	assign trig_sum = {1'b0, time_q} + {{(TW - 30){1'b0}}, req.data.timeout_ms};

	logic [TW-1:0] sum_next;
	assign sum_next = sum_q + d_rdata;

	// The head read in the previous cycle expires at the stored time.
	logic head_exp;
	assign head_exp = (len_q != '0) && (nout_q < OW'(dqtm_pkg::MaxOut)) && (d_rdata <= time_q);

	// Memory port control, driven from the sequencer state.
	always_comb begin
		d_we = 1'b0;
		s_we = 1'b0;
		t_we = 1'b0;
		d_waddr = idx_q[SW-1:0];
		s_waddr = idx_q[SW-1:0];
		d_wdata = acc_q;
		s_wdata = s_rdata;
		d_raddr = idx_q[SW-1:0];
		s_raddr = idx_q[SW-1:0];
		t_waddr = free_q;
		t_raddr = s_rdata;
		case (state_q)
			S_SHIFT_WR: begin
				// Move entry idx-1 up to idx; the read was issued at idx-1.
				d_we = 1'b1;
				s_we = 1'b1;
				d_wdata = (idx_q - LW'(1) == pos_q) ? (sum_q - trig_q) : d_rdata;
			end
			S_INS: begin
				d_we = 1'b1;
				s_we = 1'b1;
				d_waddr = pos_q[SW-1:0];
				s_waddr = pos_q[SW-1:0];
				d_wdata = acc_q;
				s_wdata = free_q;
				t_we = 1'b1;
			end
			S_UNL_WR: begin
				// Entry idx+1 moves down to idx; fold the removed delta in at pos.
				d_we = 1'b1;
				s_we = 1'b1;
				d_wdata = (idx_q + LW'(1) == pos_q) ? (d_rdata + acc_q) : d_rdata;
			end
			S_SHIFT_RD, S_UNL_RD: begin
				d_raddr = (state_q == S_SHIFT_RD) ? SW'(idx_q - LW'(1)) : SW'(idx_q + LW'(1));
				s_raddr = d_raddr;
			end
			default: begin
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	// Sequencer: one request at a time, one queue entry at a time (a read state, then a check or write state).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= '0;
			len_q <= '0;
			time_q <= '0;
			rsp_valid_q <= 1'b0;
			idx_q <= '0;
			nout_q <= '0;
			tick_q <= 1'b0;
			hold_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q <= req.data;
						idx_q <= '0;
						sum_q <= '0;
						free_q <= free_idx;
						trig_q <= trig_sum[TW] ? {TW{1'b1}} : trig_sum[TW-1:0];
						nout_q <= '0;
						case (req.data.kind)
							dqtm_pkg::KIND_SET: begin
								if (!free_any || len_q >= LW'(dqtm_pkg::Depth)) begin
									rsp_q <= '{status: dqtm_pkg::ST_FULL, slot: '0, tag: '0,
										last: 1'b1};
									rsp_valid_q <= 1'b1;
									state_q <= S_OUT;
								end else begin
									pos_q <= len_q;
									state_q <= S_SRCH_RD;
								end
							end
							dqtm_pkg::KIND_CANCEL: begin
								if (!busy_q[req.data.cancel_slot[SW-1:0]]) begin
									rsp_q <= '{status: dqtm_pkg::ST_NOT_FOUND,
										slot: req.data.cancel_slot, tag: '0, last: 1'b1};
									rsp_valid_q <= 1'b1;
									state_q <= S_OUT;
								end else begin
									state_q <= S_FIND_RD;
								end
							end
							dqtm_pkg::KIND_TICK: begin
								time_q <= req.data.now_ms;
								tick_q <= 1'b1;
								state_q <= S_TICK_RD;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SRCH_RD: begin
					state_q <= (idx_q == len_q) ? S_SHIFT_RD : S_SRCH_CHK;
					if (idx_q == len_q) begin
						acc_q <= trig_q - sum_q;
						idx_q <= len_q;
					end
				end
				S_SRCH_CHK: begin
					if (sum_next >= trig_q) begin
						pos_q <= idx_q;
						acc_q <= trig_q - sum_q;
						sum_q <= sum_next;
						idx_q <= len_q;
						state_q <= S_SHIFT_RD;
					end else begin
						sum_q <= sum_next;
						idx_q <= idx_q + LW'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= (idx_q == pos_q) ? S_INS : S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					idx_q <= idx_q - LW'(1);
					state_q <= S_SHIFT_RD;
				end
				S_INS: begin
					busy_q[free_q] <= 1'b1;
					len_q <= len_q + LW'(1);
					rsp_q <= '{status: dqtm_pkg::ST_SET_OK, slot: 4'(free_q), tag: '0,
						last: 1'b1};
					rsp_valid_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_FIND_RD: begin
					state_q <= S_FIND_CHK;
				end
				S_FIND_CHK: begin
					if (s_rdata == req_q.cancel_slot[SW-1:0]) begin
						pos_q <= idx_q + LW'(1);
						acc_q <= d_rdata;
						state_q <= S_UNL_RD;
					end else begin
						idx_q <= idx_q + LW'(1);
						state_q <= S_FIND_RD;
					end
				end
				S_UNL_RD: begin
					// The tag of an expired head arrives in the first unlink cycle.
					if (tick_q && pos_q == idx_q + LW'(1)) begin
						rsp_q.tag <= t_rdata;
					end
					if (idx_q + LW'(1) >= len_q) begin
						len_q <= len_q - LW'(1);
						if (tick_q) begin
							nout_q <= nout_q + OW'(1);
							idx_q <= '0;
							hold_q <= 1'b1;
							state_q <= S_TICK_RD;
						end else begin
							busy_q[req_q.cancel_slot[SW-1:0]] <= 1'b0;
							rsp_q <= '{status: dqtm_pkg::ST_CANCELLED,
								slot: req_q.cancel_slot, tag: '0, last: 1'b1};
							rsp_valid_q <= 1'b1;
							state_q <= S_OUT;
						end
					end else begin
						state_q <= S_UNL_WR;
					end
				end
				S_UNL_WR: begin
					idx_q <= idx_q + LW'(1);
					pos_q <= '1;
					state_q <= S_UNL_RD;
				end
				S_TICK_RD: begin
					state_q <= S_TICK_CHK;
				end
				S_TICK_CHK: begin
					if (hold_q) begin
						// The held expiry goes out; it is last unless the new head expires.
						if (!head_exp) begin
							rsp_q.last <= 1'b1;
							tick_q <= 1'b0;
						end
						hold_q <= 1'b0;
						rsp_valid_q <= 1'b1;
						state_q <= S_OUT;
					end else if (head_exp) begin
						// Head expires: record it, then unlink entry zero.
						busy_q[s_rdata] <= 1'b0;
						rsp_q <= '{status: dqtm_pkg::ST_EXPIRED, slot: 4'(s_rdata),
							tag: '0, last: 1'b0};
						pos_q <= LW'(1);
						acc_q <= d_rdata;
						state_q <= S_UNL_RD;
					end else begin
						if (nout_q == '0) begin
							rsp_q <= '{status: dqtm_pkg::ST_NONE, slot: '0, tag: '0,
								last: 1'b1};
							rsp_valid_q <= 1'b1;
						end
						tick_q <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// Hold until the result is taken; a tick then checks the new head.
					if (tick_q) begin
						if (rsp_valid_q && rsp.ready) begin
							state_q <= S_TICK_RD;
						end else if (!rsp_valid_q) begin
							state_q <= S_TICK_RD;
						end
					end else if (!rsp_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Tick results: each expiry is held until the following head has been
	// checked, so the last mark is known before the result goes out.

	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(dqtm_pkg::Depth))
		else $error("queue length beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !rsp_valid_q)
		else $error("result pending at new request");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |=> rsp_valid_q && $stable(rsp_q))
		else $error("stalled result changed");
endmodule
